// ----- hw/rtl/sfa_pkg.sv -----
package sfa_pkg;

  // Reset values of the configuration registers.
  localparam logic [31:0] GAIN_RESET   = 32'd42950;
  localparam logic [3:0]  PASSES_RESET = 4'd4;

  localparam int PARTICLE_SLOTS_DEFAULT = 512;
  localparam int STICK_SLOTS_DEFAULT    = 256;

  typedef enum logic [1:0] {
    OP_ADD_PARTICLE = 2'd0,
    OP_ADD_STICK    = 2'd1,
    OP_STEP         = 2'd2,
    OP_READ         = 2'd3
  } sfa_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } sfa_status_t;

  typedef enum logic {
    REG_GAIN   = 1'b0,
    REG_PASSES = 1'b1
  } sfa_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_RDW, S_ST_RD, S_ST_CHK, S_PA, S_PB, S_SQX, S_SQY, S_SQS,
    S_SQRT, S_DELTA, S_FRC, S_FRC2, S_PML, S_PMH, S_PSUM, S_PCLP, S_UAR, S_UAW,
    S_UBW, S_NEXT, S_RESP
  } sfa_state_t;

  // Clamp a 51-bit signed sum to the signed 48-bit velocity range.
  function automatic logic [47:0] sat48(input logic signed [50:0] v);
    logic [47:0] r;
    if (v > 51'sh0_7FFF_FFFF_FFFF) begin
      r = 48'h7FFF_FFFF_FFFF;
    end else if (v < -51'sh0_8000_0000_0000) begin
      r = 48'h8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/spring_force_accumulator_core.sv -----
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | operation, positions, velocities, stick data
// out_    | output    | out_valid/out_stall| status, slot index, particle read data
// cfg_    | input     | cfg_we             | cfg_index selects gain or pass count
//
// Add particle and add stick go from S_EXEC straight to S_RESP; a read of a valid
// index passes S_RDW in between. A step runs every live stick through the square
// root and the single shared 34x34 multiplier, once per pass, pass_count times.
// rst_n is synchronous; it clears the counts and the sequencer, not the tables.
// A finished result waits in the output register while out_stall is high; the
// next item is taken meanwhile and holds in its final state until the slot frees.
module spring_force_accumulator_core #(
  parameter int PARTICLE_SLOTS = sfa_pkg::PARTICLE_SLOTS_DEFAULT,
  parameter int STICK_SLOTS    = sfa_pkg::STICK_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [47:0] in_vel_x,
  input  logic signed [47:0] in_vel_y,
  input  logic [8:0]  in_index_a,
  input  logic [8:0]  in_index_b,
  input  logic [31:0] in_rest_length,
  input  logic        in_stick_alive,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [8:0]  out_slot_index,
  output logic signed [31:0] out_out_x,
  output logic signed [31:0] out_out_y,
  output logic signed [47:0] out_out_vx,
  output logic signed [47:0] out_out_vy,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import sfa_pkg::*;

  localparam int PIW = $clog2(PARTICLE_SLOTS);
  localparam int SIW = $clog2(STICK_SLOTS);
  localparam int IXW = (PIW > 9) ? PIW : 9;
  localparam int SXW = (SIW > 9) ? SIW : 9;
  localparam int EW  = 2 * PIW + 33;

  sfa_state_t state_r, state_nxt;

  // Latched input item.
  logic [1:0]  op_r;
  logic [31:0] inx_r, iny_r, rest_in_r;
  logic [47:0] invx_r, invy_r;
  logic [8:0]  ia_r, ib_r;
  logic        alive_in_r;

  logic [PIW-1:0] p_used_r;
  logic [SIW-1:0] s_used_r;
  logic [31:0]    gain_r;
  logic [3:0]     passes_r;
  logic [3:0]     pass_r;
  logic [SIW-1:0] stk_r;

  // Stick datapath.
  logic [PIW-1:0] ea_r, eb_r;
  logic [31:0]    rest_r, xa_r, ya_r;
  logic [32:0]    dxm_r, dym_r;
  logic           dxn_r, dyn_r;
  logic [67:0]    sq_r;
  logic [33:0]    root_r;
  logic [35:0]    rem_r;
  logic [5:0]     it_r;
  logic           dneg_r;
  logic [33:0]    dm_r;
  logic [49:0]    fm_r;
  logic [83:0]    acc_r;
  logic           axis_r;
  logic [49:0]    px_r, py_r;
  logic [67:0]    mul_p_r;
  logic [33:0]    mul_a, mul_b;

  // Result being built and output register.
  logic [1:0]  res_status_r;
  logic [8:0]  res_slot_r;
  logic [31:0] res_x_r, res_y_r;
  logic [47:0] res_vx_r, res_vy_r;
  logic        out_valid_r;

  // Memories.
  logic [63:0]    pos_mem [PARTICLE_SLOTS];
  logic [47:0]    velx_mem [PARTICLE_SLOTS];
  logic [47:0]    vely_mem [PARTICLE_SLOTS];
  logic [EW-1:0]  stk_mem [STICK_SLOTS];
  logic [63:0]    pos_rd_r;
  logic [47:0]    velx_rd_r, vely_rd_r;
  logic [EW-1:0]  stk_rd_r;

  logic           pos_we, vel_we, stk_we;
  logic [PIW-1:0] pos_raddr, vel_raddr, vel_waddr;
  logic [47:0]    velx_wdata, vely_wdata;
  logic [SIW-1:0] stk_raddr;

  logic [IXW-1:0] ia_ext, ib_ext, pu_ext;
  logic [SXW-1:0] su_ext;
  logic           p_full, s_full, ia_bad, ib_bad;
  logic           in_xfer, out_xfer, res_load;
  logic [PIW-1:0] se_a, se_b;
  logic           se_alive;

  // Per-axis push and the sqrt step.
  logic [32:0]    d_sel;
  logic           dn_sel;
  logic [67:0]    m_full;
  logic [48:0]    m_clamp;
  logic [49:0]    push;
  logic [37:0]    rem_sh;
  logic [37:0]    trial;
  logic signed [32:0] dx_s, dy_s;
  logic signed [34:0] delta_s;
  logic [34:0]    delta_m;
  logic [SIW:0]   stk_inc;
  logic [4:0]     pass_inc;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign res_load = (state_r == S_RESP) && (!out_valid_r || !out_stall);
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  assign ia_ext = IXW'(ia_r);
  assign ib_ext = IXW'(ib_r);
  assign pu_ext = IXW'(p_used_r);
  assign su_ext = SXW'(s_used_r);
  assign p_full = (p_used_r >= PIW'(PARTICLE_SLOTS - 1));
  assign s_full = (s_used_r >= SIW'(STICK_SLOTS - 1));
  assign ia_bad = (ia_ext >= pu_ext);
  assign ib_bad = (ib_ext >= pu_ext);

  assign se_a     = stk_rd_r[PIW-1:0];
  assign se_b     = stk_rd_r[2*PIW-1:PIW];
  assign se_alive = stk_rd_r[EW-1];

  assign dx_s = $signed({xa_r[31], xa_r}) - $signed({pos_rd_r[31], pos_rd_r[31:0]});
  assign dy_s = $signed({ya_r[31], ya_r}) - $signed({pos_rd_r[63], pos_rd_r[63:32]});
  assign delta_s = $signed({3'b000, rest_r}) - $signed({1'b0, root_r});
  assign delta_m = delta_s[34] ? 35'(-delta_s) : 35'(delta_s);

  assign rem_sh = {rem_r, sq_r[67:66]};
  assign trial  = {2'b00, root_r, 2'b01};

  assign d_sel  = axis_r ? dym_r : dxm_r;
  assign dn_sel = axis_r ? dyn_r : dxn_r;
  assign m_full = acc_r[83:16];
  assign m_clamp = (m_full > 68'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : m_full[48:0];
  assign push = (dneg_r != dn_sel) ? 50'(-{1'b0, m_clamp}) : {1'b0, m_clamp};

  assign stk_inc  = {1'b0, stk_r} + 1'b1;
  assign pass_inc = {1'b0, pass_r} + 1'b1;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQX: begin
        mul_a = {1'b0, dxm_r};
        mul_b = {1'b0, dxm_r};
      end
      S_SQY: begin
        mul_a = {1'b0, dym_r};
        mul_b = {1'b0, dym_r};
      end
      S_FRC: begin
        mul_a = dm_r;
        mul_b = {2'b00, gain_r};
      end
      S_PML: begin
        mul_a = {1'b0, d_sel};
        mul_b = fm_r[33:0];
      end
      S_PMH: begin
        mul_a = {1'b0, d_sel};
        mul_b = {18'd0, fm_r[49:34]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer: next state and memory controls.
  always_comb begin
    state_nxt  = state_r;
    pos_we     = 1'b0;
    vel_we     = 1'b0;
    stk_we     = 1'b0;
    pos_raddr  = ia_ext[PIW-1:0];
    vel_raddr  = ia_ext[PIW-1:0];
    vel_waddr  = p_used_r;
    velx_wdata = invx_r;
    vely_wdata = invy_r;
    stk_raddr  = stk_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sfa_op_t'(op_r))
          OP_ADD_PARTICLE: begin
            pos_we    = !p_full;
            vel_we    = !p_full;
            state_nxt = S_RESP;
          end
          OP_ADD_STICK: begin
            stk_we    = !s_full && !ia_bad && !ib_bad;
            state_nxt = S_RESP;
          end
          OP_STEP: begin
            if (passes_r == '0 || s_used_r == '0) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_ST_RD;
            end
          end
          OP_READ: begin
            state_nxt = ia_bad ? S_RESP : S_RDW;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_RDW:    state_nxt = S_RESP;
      S_ST_RD:  state_nxt = S_ST_CHK;
      S_ST_CHK: begin
        pos_raddr = se_a;
        if (!se_alive || se_a >= p_used_r || se_b >= p_used_r) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_PA;
        end
      end
      S_PA: begin
        pos_raddr = eb_r;
        state_nxt = S_PB;
      end
      S_PB:   state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_SQS;
      S_SQS:  state_nxt = S_SQRT;
      S_SQRT: begin
        if (it_r == '0) begin
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: state_nxt = S_FRC;
      S_FRC:   state_nxt = S_FRC2;
      S_FRC2:  state_nxt = S_PML;
      S_PML:   state_nxt = S_PMH;
      S_PMH:   state_nxt = S_PSUM;
      S_PSUM:  state_nxt = S_PCLP;
      S_PCLP:  state_nxt = axis_r ? S_UAR : S_PML;
      S_UAR: begin
        vel_raddr = ea_r;
        state_nxt = S_UAW;
      end
      S_UAW: begin
        vel_we     = 1'b1;
        vel_waddr  = ea_r;
        velx_wdata = sat48($signed({{3{velx_rd_r[47]}}, velx_rd_r}) +
                           $signed({px_r[49], px_r}));
        vely_wdata = sat48($signed({{3{vely_rd_r[47]}}, vely_rd_r}) +
                           $signed({py_r[49], py_r}));
        vel_raddr  = eb_r;
        state_nxt  = S_UBW;
      end
      S_UBW: begin
        vel_we     = 1'b1;
        vel_waddr  = eb_r;
        velx_wdata = sat48($signed({{3{velx_rd_r[47]}}, velx_rd_r}) -
                           $signed({px_r[49], px_r}));
        vely_wdata = sat48($signed({{3{vely_rd_r[47]}}, vely_rd_r}) -
                           $signed({py_r[49], py_r}));
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        if (stk_inc < {1'b0, s_used_r}) begin
          state_nxt = S_ST_RD;
        end else if (pass_inc < {1'b0, passes_r}) begin
          state_nxt = S_ST_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[p_used_r] <= {iny_r, inx_r};
    end
    pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (vel_we) begin
      velx_mem[vel_waddr] <= velx_wdata;
      vely_mem[vel_waddr] <= vely_wdata;
    end
    velx_rd_r <= velx_mem[vel_raddr];
    vely_rd_r <= vely_mem[vel_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[s_used_r] <= {alive_in_r, rest_in_r, ib_ext[PIW-1:0], ia_ext[PIW-1:0]};
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_used_r    <= '0;
      s_used_r    <= '0;
      gain_r      <= GAIN_RESET;
      passes_r    <= PASSES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (sfa_reg_t'(cfg_index))
          REG_GAIN:   gain_r   <= cfg_wdata;
          REG_PASSES: passes_r <= cfg_wdata[3:0];
          default:    gain_r   <= gain_r;
        endcase
      end
      if (pos_we) begin
        p_used_r <= p_used_r + 1'b1;
      end
      if (stk_we) begin
        s_used_r <= s_used_r + 1'b1;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (in_xfer) begin
      op_r       <= in_operation;
      inx_r      <= in_pos_x;
      iny_r      <= in_pos_y;
      invx_r     <= in_vel_x;
      invy_r     <= in_vel_y;
      ia_r       <= in_index_a;
      ib_r       <= in_index_b;
      rest_in_r  <= in_rest_length;
      alive_in_r <= in_stick_alive;
    end
    unique case (state_r)
      S_EXEC: begin
        res_status_r <= ST_OK;
        res_slot_r   <= '0;
        res_x_r      <= '0;
        res_y_r      <= '0;
        res_vx_r     <= '0;
        res_vy_r     <= '0;
        pass_r       <= '0;
        stk_r        <= '0;
        unique case (sfa_op_t'(op_r))
          OP_ADD_PARTICLE: begin
            if (p_full) begin
              res_status_r <= ST_FULL;
            end else begin
              res_slot_r <= pu_ext[8:0];
            end
          end
          OP_ADD_STICK: begin
            if (s_full) begin
              res_status_r <= ST_FULL;
            end else if (ia_bad || ib_bad) begin
              res_status_r <= ST_BAD_INDEX;
            end else begin
              res_slot_r <= su_ext[8:0];
            end
          end
          OP_READ: begin
            if (ia_bad) begin
              res_status_r <= ST_BAD_INDEX;
            end
          end
          default: res_slot_r <= '0;
        endcase
      end
      S_RDW: begin
        res_x_r  <= pos_rd_r[31:0];
        res_y_r  <= pos_rd_r[63:32];
        res_vx_r <= velx_rd_r;
        res_vy_r <= vely_rd_r;
      end
      S_ST_CHK: begin
        ea_r   <= se_a;
        eb_r   <= se_b;
        rest_r <= stk_rd_r[2*PIW+31:2*PIW];
      end
      S_PA: begin
        xa_r <= pos_rd_r[31:0];
        ya_r <= pos_rd_r[63:32];
      end
      S_PB: begin
        dxn_r <= dx_s[32];
        dyn_r <= dy_s[32];
        dxm_r <= dx_s[32] ? 33'(-dx_s) : 33'(dx_s);
        dym_r <= dy_s[32] ? 33'(-dy_s) : 33'(dy_s);
      end
      S_SQY: sq_r <= mul_p_r;
      S_SQS: begin
        sq_r   <= sq_r + mul_p_r;
        root_r <= '0;
        rem_r  <= '0;
        it_r   <= 6'd33;
      end
      S_SQRT: begin
        sq_r <= {sq_r[65:0], 2'b00};
        it_r <= it_r - 1'b1;
        if (rem_sh >= trial) begin
          rem_r  <= 36'(rem_sh - trial);
          root_r <= {root_r[32:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[35:0];
          root_r <= {root_r[32:0], 1'b0};
        end
      end
      S_DELTA: begin
        dneg_r <= delta_s[34];
        dm_r   <= delta_m[33:0];
        axis_r <= 1'b0;
      end
      S_FRC2: fm_r <= mul_p_r[65:16];
      S_PMH:  acc_r <= {16'd0, mul_p_r};
      S_PSUM: acc_r <= acc_r + {mul_p_r[49:0], 34'd0};
      S_PCLP: begin
        axis_r <= 1'b1;
        if (axis_r) begin
          py_r <= push;
        end else begin
          px_r <= push;
        end
      end
      S_NEXT: begin
        if (stk_inc < {1'b0, s_used_r}) begin
          stk_r <= stk_inc[SIW-1:0];
        end else begin
          stk_r  <= '0;
          pass_r <= pass_inc[3:0];
        end
      end
      default: it_r <= it_r;
    endcase
    if (res_load) begin
      out_status     <= res_status_r;
      out_slot_index <= res_slot_r;
      out_out_x      <= res_x_r;
      out_out_y      <= res_y_r;
      out_out_vx     <= res_vx_r;
      out_out_vy     <= res_vy_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_p_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    p_used_r <= PIW'(PARTICLE_SLOTS - 1))
    else $error("particle count beyond table");
  a_s_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s_used_r <= SIW'(STICK_SLOTS - 1))
    else $error("stick count beyond table");
  a_sqrt_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT && it_r == '0) |=> state_r == S_DELTA)
    else $error("square root did not finish");
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_EXEC)
    else $error("accepted item not executed");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_valid_r && out_stall) |=> state_r == S_RESP)
    else $error("result dropped while output busy");
`endif

endmodule

// ----- tb/tb_spring_force_accumulator_core.sv -----
`timescale 1ns / 100ps

module tb_spring_force_accumulator_core;
  import sfa_pkg::*;

  // Table sizes of the instance under test; the predictor uses the same sizes.
  localparam int PSLOTS = 512;
  localparam int SSLOTS = 256;

  // One input transfer, one field per port.
  typedef struct {
    sfa_op_t            op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic [8:0]         idx_a;
    logic [8:0]         idx_b;
    logic [31:0]        rest;
    logic               alive;
  } spring_item_t;

  // One result transfer.
  typedef struct {
    sfa_status_t status;
    logic [8:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [47:0] vx;
    logic [47:0] vy;
  } spring_reply_t;

  // The scoreboard keeps its own copy of both tables and the registers, and
  // a queue of replies still owed by the block, oldest first.
  class spring_scoreboard;
    int          pos_x_tab[PSLOTS];
    int          pos_y_tab[PSLOTS];
    longint      vel_x_tab[PSLOTS];
    longint      vel_y_tab[PSLOTS];
    int          stick_a[SSLOTS];
    int          stick_b[SSLOTS];
    logic [31:0] stick_rest[SSLOTS];
    bit          stick_live[SSLOTS];
    int unsigned particles;
    int unsigned sticks;
    logic [31:0] gain;
    logic [3:0]  passes;
    spring_reply_t owed[$];
    int          errors;

    function new();
      particles = 0;
      sticks    = 0;
      gain      = GAIN_RESET;
      passes    = PASSES_RESET;
      errors    = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(input string what);
      $display("ERROR at %0t ns: %s", $realtime, what);
      errors++;
    endtask

    function void set_reg(sfa_reg_t r, logic [31:0] v);
      if (r == REG_GAIN) begin
        gain = v;
      end else begin
        passes = v[3:0];
      end
    endfunction

    function logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Floor of the square root of a sum of two squares; the result fits 34 bits.
    function logic [63:0] floor_root(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int k = 33; k >= 0; k--) begin
        c = r | (64'd1 << k);
        if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
    endfunction

    // Force times offset, scaled down by 2^16, magnitude capped at 2^48.
    function longint scaled_push(logic [63:0] fm, bit fneg, longint d);
      logic [127:0] p;
      p = ({64'd0, fm} * {64'd0, magnitude(d)}) >> 16;
      if (p > (128'd1 << 48)) p = 128'd1 << 48;
      return (fneg != (d < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function longint clamp_vel(longint v);
      if (v > 64'sd140737488355327) return 64'sd140737488355327;
      if (v < -64'sd140737488355328) return -64'sd140737488355328;
      return v;
    endfunction

    function void apply_stick(int s);
      int a;
      int b;
      longint dx;
      longint dy;
      longint delta;
      longint px;
      longint py;
      logic [127:0] sq;
      logic [127:0] f;
      logic [63:0] span;
      a = stick_a[s];
      b = stick_b[s];
      if (!stick_live[s] || a >= particles || b >= particles) return;
      dx = longint'(pos_x_tab[a]) - longint'(pos_x_tab[b]);
      dy = longint'(pos_y_tab[a]) - longint'(pos_y_tab[b]);
      sq = {64'd0, magnitude(dx)} * {64'd0, magnitude(dx)}
         + {64'd0, magnitude(dy)} * {64'd0, magnitude(dy)};
      span = floor_root(sq);
      delta = longint'({32'd0, stick_rest[s]}) - longint'(span);
      f = {64'd0, magnitude(delta)} * {96'd0, gain};
      px = scaled_push(f[79:16], delta < 0, dx);
      py = scaled_push(f[79:16], delta < 0, dy);
      vel_x_tab[a] = clamp_vel(vel_x_tab[a] + px);
      vel_y_tab[a] = clamp_vel(vel_y_tab[a] + py);
      vel_x_tab[b] = clamp_vel(vel_x_tab[b] - px);
      vel_y_tab[b] = clamp_vel(vel_y_tab[b] - py);
    endfunction

    function void note_input(spring_item_t it);
      spring_reply_t r;
      r = '{ST_OK, '0, '0, '0, '0, '0};
      case (it.op)
        OP_ADD_PARTICLE: begin
          if (particles >= PSLOTS - 1) begin
            r.status = ST_FULL;
          end else begin
            pos_x_tab[particles] = it.pos_x;
            pos_y_tab[particles] = it.pos_y;
            vel_x_tab[particles] = longint'(it.vel_x);
            vel_y_tab[particles] = longint'(it.vel_y);
            r.slot = 9'(particles);
            particles++;
          end
        end
        OP_ADD_STICK: begin
          if (sticks >= SSLOTS - 1) begin
            r.status = ST_FULL;
          end else if (it.idx_a >= particles || it.idx_b >= particles) begin
            r.status = ST_BAD_INDEX;
          end else begin
            stick_a[sticks]    = int'(it.idx_a);
            stick_b[sticks]    = int'(it.idx_b);
            stick_rest[sticks] = it.rest;
            stick_live[sticks] = it.alive;
            r.slot = 9'(sticks);
            sticks++;
          end
        end
        OP_STEP: begin
          for (int p = 0; p < passes; p++) begin
            for (int s = 0; s < sticks; s++) apply_stick(s);
          end
        end
        default: begin
          if (it.idx_a >= particles) begin
            r.status = ST_BAD_INDEX;
          end else begin
            r.x  = pos_x_tab[it.idx_a];
            r.y  = pos_y_tab[it.idx_a];
            r.vx = vel_x_tab[it.idx_a][47:0];
            r.vy = vel_y_tab[it.idx_a][47:0];
          end
        end
      endcase
      owed.push_back(r);
    endfunction

    task check_result(spring_reply_t got);
      spring_reply_t e;
      if (owed.size() == 0) begin
        report("result transfer with no result outstanding");
      end else begin
        e = owed.pop_front();
        if (got.status !== e.status)
          report($sformatf("status %0d, wanted %0d", got.status, e.status));
        if (got.slot !== e.slot)
          report($sformatf("slot_index %0d, wanted %0d", got.slot, e.slot));
        if (got.x !== e.x) report($sformatf("out_x %h, wanted %h", got.x, e.x));
        if (got.y !== e.y) report($sformatf("out_y %h, wanted %h", got.y, e.y));
        if (got.vx !== e.vx) report($sformatf("out_vx %h, wanted %h", got.vx, e.vx));
        if (got.vy !== e.vy) report($sformatf("out_vy %h, wanted %h", got.vy, e.vy));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [47:0] in_vel_x;
  logic signed [47:0] in_vel_y;
  logic [8:0]  in_index_a;
  logic [8:0]  in_index_b;
  logic [31:0] in_rest_length;
  logic        in_stick_alive;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [8:0]  out_slot_index;
  logic signed [31:0] out_out_x;
  logic signed [31:0] out_out_y;
  logic signed [47:0] out_out_vx;
  logic signed [47:0] out_out_vy;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  spring_scoreboard sb = new();

  // When quiet is set, neither side idles. A request for a long hold-off is
  // served by the receiver process, which counts the stalled cycles itself.
  bit quiet;
  bit hold_request;

  spring_force_accumulator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .in_index_a(in_index_a), .in_index_b(in_index_b),
    .in_rest_length(in_rest_length), .in_stick_alive(in_stick_alive),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot_index(out_slot_index),
    .out_out_x(out_out_x), .out_out_y(out_out_y),
    .out_out_vx(out_out_vx), .out_out_vy(out_out_vy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Every result transfer is checked at the rising edge at which it happens.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{sfa_status_t'(out_status), out_slot_index, out_out_x,
                        out_out_y, out_out_vx, out_out_vy});
    end
  end

  // The receiver stalls in random bursts. A long hold-off keeps out_stall high
  // so long that the block backs up into its input.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
    end
  end

  // Offers one item and holds it until the transfer. Called at a falling edge,
  // it returns at a falling edge, after an optional random gap.
  task automatic send(input spring_item_t it);
    in_valid       <= 1'b1;
    in_operation   <= it.op;
    in_pos_x       <= it.pos_x;
    in_pos_y       <= it.pos_y;
    in_vel_x       <= it.vel_x;
    in_vel_y       <= it.vel_y;
    in_index_a     <= it.idx_a;
    in_index_b     <= it.idx_b;
    in_rest_length <= it.rest;
    in_stick_alive <= it.alive;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  function automatic spring_item_t blank_item(sfa_op_t op);
    spring_item_t it;
    it = '{op, '0, '0, '0, '0, '0, '0, '0, 1'b0};
    return it;
  endfunction

  task automatic load_particle(input logic [31:0] x, input logic [31:0] y,
                               input logic [47:0] vx, input logic [47:0] vy);
    spring_item_t it;
    it = blank_item(OP_ADD_PARTICLE);
    it.pos_x = x;
    it.pos_y = y;
    it.vel_x = vx;
    it.vel_y = vy;
    // Stick fields carry noise; the block has to ignore them here.
    it.idx_a = 9'($urandom);
    it.rest  = $urandom;
    send(it);
  endtask

  task automatic load_stick(input int a, input int b, input logic [31:0] rest,
                            input logic alive);
    spring_item_t it;
    it = blank_item(OP_ADD_STICK);
    it.idx_a = 9'(a);
    it.idx_b = 9'(b);
    it.rest  = rest;
    it.alive = alive;
    it.pos_x = $urandom;
    send(it);
  endtask

  task automatic run_step();
    spring_item_t it;
    it = blank_item(OP_STEP);
    it.idx_a = 9'($urandom);
    send(it);
  endtask

  task automatic read_particle(input int a);
    spring_item_t it;
    it = blank_item(OP_READ);
    it.idx_a = 9'(a);
    it.vel_y = 48'({$urandom, $urandom});
    send(it);
  endtask

  // Lets every owed result arrive, then a margin for the block to settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Drives one register write for the next rising edge; the caller drops
  // the write enable after the last write.
  task automatic write_reg(input sfa_reg_t r, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(negedge clk);
    sb.set_reg(r, v);
  endtask

  task automatic configure(input logic [31:0] g, input logic [3:0] p);
    drain();
    write_reg(REG_GAIN, g);
    write_reg(REG_PASSES, {28'd0, p});
    cfg_we <= 1'b0;
  endtask

  // Positions are either near the origin, so that forces stay in range, or
  // fully random, so that the products saturate.
  function automatic logic [31:0] pick_pos();
    if ($urandom_range(0, 1) == 0) return 32'($signed($urandom_range(0, 20'hFFFFF)) - 'h80000);
    return $urandom;
  endfunction

  function automatic logic [47:0] pick_vel();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) v = 64'($signed(v[31:0]) >>> 8);
    return v[47:0];
  endfunction

  // Mostly well-formed work: valid sticks and reads of loaded particles, with
  // a minority of bad indices. Table sizes stay modest so steps stay cheap.
  task automatic random_item();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = sb.particles;
    if (r < 40 && n < 200) begin
      load_particle(pick_pos(), pick_pos(), pick_vel(), pick_vel());
    end else if (r < 65 && sb.sticks < 40 && n > 0) begin
      if ($urandom_range(0, 6) != 0) begin
        load_stick($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'h40000) : $urandom,
                   $urandom_range(0, 3) != 0);
      end else begin
        load_stick($urandom_range(0, 511), $urandom_range(0, 511), $urandom,
                   1'($urandom));
      end
    end else if (r < 71) begin
      run_step();
    end else if (n > 0 && $urandom_range(0, 6) != 0) begin
      read_particle($urandom_range(0, n - 1));
    end else begin
      read_particle($urandom_range(0, 511));
    end
  endtask

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_STEP;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_vel_x       = '0;
    in_vel_y       = '0;
    in_index_a     = '0;
    in_index_b     = '0;
    in_rest_length = '0;
    in_stick_alive = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_GAIN;
    cfg_wdata      = '0;
    quiet          = 1'b0;
    hold_request   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty tables, field extremes, a stick on one particle,
    // a dead stick, bad indices on either end, and the register extremes.
    read_particle(0);
    load_stick(0, 0, 32'h0001_0000, 1'b1);
    load_particle(32'h7FFF_FFFF, 32'h8000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
    load_particle(32'h8000_0000, 32'h7FFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
    load_particle(32'h0000_0000, 32'h0000_0000, 48'h0, 48'h0);
    load_particle(32'h0003_0000, 32'hFFFC_0000, 48'h0000_0123_4567, 48'hFFFF_FF00_0000);
    load_stick(0, 1, 32'hFFFF_FFFF, 1'b1);
    load_stick(2, 3, 32'h0002_8000, 1'b1);
    load_stick(2, 2, 32'h0001_0000, 1'b1);
    load_stick(1, 3, 32'h0000_0000, 1'b0);
    load_stick(0, 511, 32'h0001_0000, 1'b1);
    load_stick(4, 0, 32'h0001_0000, 1'b1);
    run_step();
    read_particle(0);
    read_particle(1);
    read_particle(2);
    read_particle(3);
    read_particle(511);
    configure(32'h0000_0000, 4'd0);
    run_step();
    read_particle(3);
    configure(32'hFFFF_FFFF, 4'd1);
    run_step();
    read_particle(2);
    read_particle(3);

    // Random part in phases, each with its own register setting. The first
    // phase carries the long receiver hold-off.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure($urandom, 4'd2);
        1: configure(32'h0000_0000, 4'd15);
        2: configure(32'hFFFF_FFFF, 4'd1);
        3: configure($urandom, 4'd3);
        4: configure(GAIN_RESET, PASSES_RESET);
        default: configure($urandom, 4'($urandom_range(1, 4)));
      endcase
      if (ph == 0) hold_request = 1'b1;
      repeat (60) random_item();
    end

    // Last part, without idling: fill the stick table to the brim and past it.
    configure($urandom, 4'd1);
    quiet = 1'b1;
    while (sb.sticks < SSLOTS - 1) begin
      load_stick($urandom_range(0, sb.particles - 1), $urandom_range(0, sb.particles - 1),
                 $urandom, 1'b0);
    end
    // A full stick table wins over the bad index.
    load_stick(511, 511, $urandom, 1'b1);
    load_stick(0, 1, $urandom, 1'b1);
    run_step();
    read_particle(sb.particles - 1);
    read_particle(511);
    read_particle($urandom_range(0, sb.particles - 1));
    drain();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
